// ===== design/pkvt_pkg.sv =====
// Package with sizes, codes, types and the sequencer state for the per-context key/value table.
package pkvt_pkg;

  localparam int CONTEXT_SLOTS    = 16;
  localparam int ENTRIES_PER_SLOT = 16;

  localparam int CTX_W    = 32;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int MASK_W   = 16;
  localparam int SLOT_W   = $clog2(CONTEXT_SLOTS);
  localparam int CNT_W    = $clog2(CONTEXT_SLOTS + 1);
  localparam int FILL_W   = $clog2(ENTRIES_PER_SLOT + 1);
  localparam int ADDR_W   = $clog2(CONTEXT_SLOTS * ENTRIES_PER_SLOT);
  localparam int DEPTH    = CONTEXT_SLOTS * ENTRIES_PER_SLOT;

  localparam logic ACT_LOOKUP  = 1'b0;
  localparam logic ACT_STORE   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ESCAN,
    ST_RECLAIM,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } mem_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } mem_rsp_t;

endpackage

// ===== design/pkvt_entry_mem.sv =====
// Entry store: one key/value memory with a single port and registered read data.
module pkvt_entry_mem
  import pkvt_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];
  mem_rsp_t         rsp_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.addr] <= req.key;
      val_mem[req.addr] <= req.value;
    end
    if (req.rd_en) begin
      rsp_r.key   <= key_mem[req.addr];
      rsp_r.value <= val_mem[req.addr];
    end
  end

  assign rsp = rsp_r;

endmodule

// ===== design/pkvt_seq.sv =====
// Sequencer with the slot table: scans slots and entries one per cycle with separate compares.
module pkvt_seq
  import pkvt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_action,
  input  logic [CTX_W-1:0]  in_context_id,
  input  logic [KEY_W-1:0]  in_entry_key,
  input  logic [VAL_W-1:0]  in_entry_value,
  input  logic [MASK_W-1:0] in_live_mask,
  output logic              busy,
  output logic              out_valid,
  output logic              out_hit,
  output logic [VAL_W-1:0]  out_found_value,
  output logic              out_status,
  output mem_req_t          mem_req,
  input  mem_rsp_t          mem_rsp
);

  state_t state_r, state_nxt;

  logic [CTX_W-1:0]  slot_ctx_r  [CONTEXT_SLOTS];
  logic [FILL_W-1:0] slot_fill_r [CONTEXT_SLOTS];
  logic [CNT_W-1:0]  siu_r, siu_nxt;

  logic              act_r;
  logic [CTX_W-1:0]  ctx_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  logic [MASK_W-1:0] mask_r;

  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [FILL_W-1:0] j_r, j_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SLOT_W-1:0] tgt_r, tgt_nxt;
  logic              new_r, new_nxt;
  logic [SLOT_W-1:0] free_r, free_nxt;
  logic              free_vld_r, free_vld_nxt;
  logic              pend_r, pend_nxt;
  logic              hit_r, hit_nxt;
  logic [VAL_W-1:0]  found_r, found_nxt;
  logic              status_r, status_nxt;

  logic              slot_we;
  logic [SLOT_W-1:0] slot_widx;
  logic [CTX_W-1:0]  slot_wctx;
  logic [FILL_W-1:0] slot_wfill;

  logic [SLOT_W-1:0] cur_idx;
  logic [CTX_W-1:0]  cur_ctx;
  logic [FILL_W-1:0] cur_fill;
  logic [FILL_W-1:0] tgt_fill;
  logic              accept, at_end, ctx_match, list_full, key_match, more_entries;
  logic              room_left, live, last_slot, claim_ok;
  logic [MASK_W-1:0] mask_shift;
  logic [FILL_W-1:0] wr_pos;
  logic [CNT_W-1:0]  tgt_top;

  assign accept       = start && (state_r == ST_IDLE);
  assign cur_idx      = i_r[SLOT_W-1:0];
  assign cur_ctx      = slot_ctx_r[cur_idx];
  assign cur_fill     = slot_fill_r[cur_idx];
  assign tgt_fill     = slot_fill_r[tgt_r];
  assign at_end       = (i_r == siu_r);
  assign ctx_match    = (cur_ctx == ctx_r);
  assign list_full    = (cur_fill >= FILL_W'(ENTRIES_PER_SLOT));
  assign key_match    = pend_r && (mem_rsp.key == key_r);
  assign more_entries = (j_r < fill_r);
  assign room_left    = (siu_r < CNT_W'(CONTEXT_SLOTS));
  // Slots past the mask width have no live bit; the shift leaves zero for them.
  assign mask_shift   = mask_r >> i_r;
  assign live         = mask_shift[0];
  assign last_slot    = (i_r == CNT_W'(CONTEXT_SLOTS - 1));
  assign claim_ok     = free_vld_r || !live;
  assign wr_pos       = new_r ? '0 : tgt_fill;
  assign tgt_top      = CNT_W'(tgt_r) + CNT_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_action == ACT_STORE && in_context_id == '0) state_nxt = ST_DONE;
          else                                                state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (at_end) begin
          if (act_r == ACT_LOOKUP)         state_nxt = ST_DONE;
          else if (free_vld_r || room_left) state_nxt = ST_WRITE;
          else                              state_nxt = ST_RECLAIM;
        end else if (ctx_match) begin
          if (act_r == ACT_LOOKUP) state_nxt = ST_ESCAN;
          else if (list_full)      state_nxt = ST_DONE;
          else                     state_nxt = ST_WRITE;
        end
      end
      ST_ESCAN: begin
        if (key_match || !more_entries) state_nxt = ST_DONE;
      end
      ST_RECLAIM: begin
        if (last_slot) state_nxt = claim_ok ? ST_WRITE : ST_DONE;
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    i_nxt        = i_r;
    j_nxt        = j_r;
    fill_nxt     = fill_r;
    tgt_nxt      = tgt_r;
    new_nxt      = new_r;
    free_nxt     = free_r;
    free_vld_nxt = free_vld_r;
    pend_nxt     = 1'b0;
    hit_nxt      = hit_r;
    found_nxt    = found_r;
    status_nxt   = status_r;
    siu_nxt      = siu_r;
    slot_we      = 1'b0;
    slot_widx    = tgt_r;
    slot_wctx    = ctx_r;
    slot_wfill   = wr_pos + FILL_W'(1);
    mem_req      = '0;
    mem_req.key  = key_r;
    mem_req.value = val_r;
    mem_req.addr = ADDR_W'(ADDR_W'(tgt_r) * ADDR_W'(ENTRIES_PER_SLOT)) + ADDR_W'(j_r);
    unique case (state_r)
      ST_IDLE: begin
        i_nxt        = '0;
        free_vld_nxt = 1'b0;
        hit_nxt      = 1'b0;
        found_nxt    = '0;
        status_nxt   = (in_action == ACT_STORE && in_context_id == '0) ? STATUS_FULL
                                                                       : STATUS_OK;
      end
      ST_SCAN: begin
        if (at_end) begin
          if (act_r == ACT_STORE) begin
            new_nxt = 1'b1;
            if (free_vld_r) begin
              tgt_nxt = free_r;
            end else if (room_left) begin
              tgt_nxt = siu_r[SLOT_W-1:0];
            end else begin
              i_nxt        = '0;
              siu_nxt      = '0;
              free_vld_nxt = 1'b0;
            end
          end
        end else if (ctx_match) begin
          tgt_nxt  = cur_idx;
          fill_nxt = cur_fill;
          j_nxt    = '0;
          new_nxt  = 1'b0;
          if (act_r == ACT_STORE && list_full) status_nxt = STATUS_FULL;
        end else begin
          // An emptied slot below the high-water mark is the first choice for a new context.
          if (act_r == ACT_STORE && cur_ctx == '0 && !free_vld_r) begin
            free_nxt     = cur_idx;
            free_vld_nxt = 1'b1;
          end
          i_nxt = i_r + CNT_W'(1);
        end
      end
      ST_ESCAN: begin
        // Reads are pipelined: the compare sees the entry issued in the previous cycle.
        if (key_match) begin
          hit_nxt   = 1'b1;
          found_nxt = mem_rsp.value;
        end else if (more_entries) begin
          mem_req.rd_en = 1'b1;
          j_nxt         = j_r + FILL_W'(1);
          pend_nxt      = 1'b1;
        end
      end
      ST_RECLAIM: begin
        if (live) begin
          siu_nxt = i_r + CNT_W'(1);
        end else begin
          slot_we    = 1'b1;
          slot_widx  = cur_idx;
          slot_wctx  = '0;
          slot_wfill = '0;
          if (!free_vld_r) begin
            free_nxt     = cur_idx;
            free_vld_nxt = 1'b1;
          end
        end
        if (last_slot) begin
          tgt_nxt = free_vld_r ? free_r : cur_idx;
          if (!claim_ok) status_nxt = STATUS_FULL;
        end else begin
          i_nxt = i_r + CNT_W'(1);
        end
      end
      ST_WRITE: begin
        mem_req.wr_en = 1'b1;
        mem_req.addr  = ADDR_W'(ADDR_W'(tgt_r) * ADDR_W'(ENTRIES_PER_SLOT)) + ADDR_W'(wr_pos);
        slot_we       = 1'b1;
        if (tgt_top > siu_r) siu_nxt = tgt_top;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      siu_r   <= '0;
      pend_r  <= 1'b0;
      for (int s = 0; s < CONTEXT_SLOTS; s++) begin
        slot_ctx_r[s]  <= '0;
        slot_fill_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      siu_r   <= siu_nxt;
      pend_r  <= pend_nxt;
      if (slot_we) begin
        slot_ctx_r[slot_widx]  <= slot_wctx;
        slot_fill_r[slot_widx] <= slot_wfill;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_action;
      ctx_r  <= in_context_id;
      key_r  <= in_entry_key;
      val_r  <= in_entry_value;
      mask_r <= in_live_mask;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    fill_r     <= fill_nxt;
    tgt_r      <= tgt_nxt;
    new_r      <= new_nxt;
    free_r     <= free_nxt;
    free_vld_r <= free_vld_nxt;
    hit_r      <= hit_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_DONE);
  assign out_hit         = hit_r;
  assign out_found_value = found_r;
  assign out_status      = status_r;

endmodule

// ===== design/per_context_key_value_table_core.sv =====
// Top level of the per-context key/value table: sequencer with slot table and entry memory.
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+----------------------------
//   request  | in_action in_context_id in_entry_key           | start high while busy low
//            | in_entry_value in_live_mask                    |
//   result   | out_hit out_found_value out_status             | out_valid, one cycle strobe
//
// Busy covers, for a lookup, the slot scan up to its context's slot k, then its n entry
// reads (one per cycle, compared on registered read data); with no match, the s used slots.
// A store scans to slot k and appends there unless that list is full; a new context is written
// after the scan or a reclaim pass over all slots (no write if none is freed); id 0 is refused.
// Reset empties every slot and clears the high-water mark; entry memory is not cleared.
// The result strobe comes in the last busy cycle; the receiver cannot stall.
module per_context_key_value_table_core
  import pkvt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_action,
  input  logic [CTX_W-1:0]  in_context_id,
  input  logic [KEY_W-1:0]  in_entry_key,
  input  logic [VAL_W-1:0]  in_entry_value,
  input  logic [MASK_W-1:0] in_live_mask,
  output logic              out_valid,
  output logic              out_hit,
  output logic [VAL_W-1:0]  out_found_value,
  output logic              out_status
);

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  pkvt_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_action       (in_action),
    .in_context_id   (in_context_id),
    .in_entry_key    (in_entry_key),
    .in_entry_value  (in_entry_value),
    .in_live_mask    (in_live_mask),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_found_value (out_found_value),
    .out_status      (out_status),
    .mem_req         (mem_req),
    .mem_rsp         (mem_rsp)
  );

  pkvt_entry_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

endmodule

// ===== design/pkvt_checker.sv =====
// Port-level checker for the table core and the bind that attaches it.
module pkvt_checker
  import pkvt_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic             out_hit,
  input logic [VAL_W-1:0] out_found_value,
  input logic             out_status
);

  // An accepted request occupies the block in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy afterwards");

  // Each request gives one strobe, and the block frees up right after it.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle or block still busy");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe without a request in flight");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_status == STATUS_OK))
    else $error("hit reported together with a failure status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_found_value == '0))
    else $error("nonzero value on a miss or a store");

endmodule

bind per_context_key_value_table_core pkvt_checker u_pkvt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_hit         (out_hit),
  .out_found_value (out_found_value),
  .out_status      (out_status)
);
